// ===== rtl/ufod_pkg.sv =====
// ----------------------------------------------------------------------------
// Ultrasonic frame obstacle detector package
// Shared types and constants for the frame detector modules.
// ----------------------------------------------------------------------------
package ufod_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned PosW      = 5;
  localparam int unsigned ReportW   = 7;
  localparam int unsigned SkipW     = 5;
  localparam int unsigned HoldW     = 3;
  localparam int unsigned CfgIdxW   = 2;

  localparam logic [ByteW-1:0] SyncByte    = 8'h76;
  localparam logic [ByteW-1:0] ZeroByte    = 8'h00;
  localparam logic [PosW-1:0]  LastPos     = 5'd16;
  localparam logic [PosW-1:0]  FirstSumPos = 5'd2;
  localparam logic [PosW-1:0]  LastSumPos  = 5'd15;
  localparam int unsigned      FirstSensor = 4;
  localparam logic [SkipW-1:0] FullSkip    = 5'd16;

  // Reset values of the configuration registers.
  localparam logic               EnabledRst   = 1'b1;
  localparam logic [ByteW-1:0]   ThresholdRst = 8'd20;
  localparam logic [ReportW-1:0] FrontRst     = 7'h1C;

  typedef enum logic [CfgIdxW-1:0] {
    CfgEnabled   = 2'd0,
    CfgThreshold = 2'd1,
    CfgFront     = 2'd2,
    CfgUnused    = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    StHeaderBad   = 2'd0,
    StChecksumBad = 2'd1,
    StFrameValid  = 2'd2,
    StDisabled    = 2'd3
  } status_e;

  typedef struct packed {
    logic               enabled;
    logic [ByteW-1:0]   near_threshold;
    logic [ReportW-1:0] front_mask;
  } cfg_t;

  typedef struct packed {
    status_e            frame_status;
    logic [ReportW-1:0] near_mask;
    logic               obstacle_alert;
    logic [SkipW-1:0]   skip_count;
  } result_t;

endpackage

// ===== rtl/ultrasonic_frame_obstacle_detector.sv =====
// ----------------------------------------------------------------------------
// Ultrasonic frame obstacle detector
// Frames the sensor serial stream into 17-word windows and reports one
// status per window, with near mask, obstacle alert and resync skip count.
// ----------------------------------------------------------------------------
// The block takes one received word per clock cycle, and every word goes
// through an input register and then a single frame stage, so the only limit
// on rate is the result register: a window's last word waits in the input
// register while an earlier result has not been taken, and all other words
// keep flowing. A result is registered at the clock edge that accepts its
// last word and stays until out_ready_i takes it; the stage that tracks
// position, header, checksum and near mask runs once per word. After a bad
// header the block silently discards skip_count words before it starts a new
// window, and those discarded words still pass through the input register.
// Configuration writes are always accepted and should only be made while the
// block is idle. Only the low seven bits of the near mask are reported and
// tested against the front mask.
module ultrasonic_frame_obstacle_detector #(
  parameter int unsigned SENSORS   = 7,
  parameter int unsigned ARM_COUNT = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write channel.
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ufod_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ufod_pkg::ByteW-1:0]    cfg_data_i,
  // Received word channel.
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ufod_pkg::ByteW-1:0]    rx_byte_i,
  // Result channel.
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    frame_status_o,
  output logic [ufod_pkg::ReportW-1:0]  near_mask_o,
  output logic                          obstacle_alert_o,
  output logic [ufod_pkg::SkipW-1:0]    skip_count_o
);

  ufod_pkg::cfg_t             cfg;
  ufod_pkg::result_t          result;
  logic                       byte_valid;
  logic [ufod_pkg::ByteW-1:0] byte_data;
  logic                       byte_take;

  ufod_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ufod_in_reg u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .rx_byte_i    (rx_byte_i),
    .byte_valid_o (byte_valid),
    .byte_o       (byte_data),
    .byte_take_i  (byte_take)
  );

  ufod_frame #(
    .SENSORS   (SENSORS),
    .ARM_COUNT (ARM_COUNT)
  ) u_frame (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .byte_valid_i (byte_valid),
    .byte_i       (byte_data),
    .byte_take_o  (byte_take),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .result_o     (result)
  );

  assign frame_status_o   = result.frame_status;
  assign near_mask_o      = result.near_mask;
  assign obstacle_alert_o = result.obstacle_alert;
  assign skip_count_o     = result.skip_count;

endmodule

// ===== rtl/ufod_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Configuration registers
// Holds enable, near threshold and front mask, written by index.
// ----------------------------------------------------------------------------
module ufod_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ufod_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ufod_pkg::ByteW-1:0]    cfg_data_i,
  output ufod_pkg::cfg_t                cfg_o
);

  ufod_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (ufod_pkg::cfg_idx_e'(cfg_index_i))
        ufod_pkg::CfgEnabled:   cfg_d.enabled        = cfg_data_i[0];
        ufod_pkg::CfgThreshold: cfg_d.near_threshold = cfg_data_i;
        ufod_pkg::CfgFront:     cfg_d.front_mask     = cfg_data_i[ufod_pkg::ReportW-1:0];
        default:                cfg_d                = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enabled        <= ufod_pkg::EnabledRst;
      cfg_q.near_threshold <= ufod_pkg::ThresholdRst;
      cfg_q.front_mask     <= ufod_pkg::FrontRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/ufod_in_reg.sv =====
// ----------------------------------------------------------------------------
// Input register
// Captures one received word and holds it until the frame stage takes it.
// ----------------------------------------------------------------------------
module ufod_in_reg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [ufod_pkg::ByteW-1:0] rx_byte_i,
  output logic                       byte_valid_o,
  output logic [ufod_pkg::ByteW-1:0] byte_o,
  input  logic                       byte_take_i
);

  logic                       valid_q, valid_d;
  logic [ufod_pkg::ByteW-1:0] byte_q;

  // The register refills in the same cycle that the frame stage drains it.
  assign in_ready_o = !valid_q || byte_take_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= rx_byte_i;
    end
  end

  assign byte_valid_o = valid_q;
  assign byte_o       = byte_q;

endmodule

// ===== rtl/ufod_frame.sv =====
// ----------------------------------------------------------------------------
// Frame stage
// Tracks the window position, header, checksum, near mask, resync search and
// alert holdoff, and registers one result at the last word of each window.
// ----------------------------------------------------------------------------
module ufod_frame #(
  parameter int unsigned SENSORS   = 7,
  parameter int unsigned ARM_COUNT = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ufod_pkg::cfg_t             cfg_i,
  input  logic                       byte_valid_i,
  input  logic [ufod_pkg::ByteW-1:0] byte_i,
  output logic                       byte_take_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output ufod_pkg::result_t          result_o
);

  localparam logic [ufod_pkg::HoldW-1:0] ArmCnt = ufod_pkg::HoldW'(ARM_COUNT);

  logic [ufod_pkg::PosW-1:0]  pos_q, pos_d;
  logic [ufod_pkg::SkipW-1:0] skip_q, skip_d;
  logic                       hdr1_q, hdr1_d;
  logic                       hdr2_q, hdr2_d;
  logic [ufod_pkg::ByteW-1:0] sum_q, sum_d;
  logic [SENSORS-1:0]         mask_q, mask_d;
  logic [ufod_pkg::PosW-1:0]  pend_q, pend_d;
  logic [ufod_pkg::PosW-1:0]  found_q, found_d;
  logic [ufod_pkg::HoldW-1:0] hold_q, hold_d;
  logic                       out_valid_q, out_valid_d;
  ufod_pkg::result_t          result_q, result_d;

  logic                       emit;
  logic                       last_word;
  logic [SENSORS-1:0]         near_hit;
  logic [ufod_pkg::ReportW-1:0] mask_report;

  // Only the word that closes a window needs room in the result register;
  // every other word, skipped words included, is processed right away.
  assign last_word   = (skip_q == '0) && (pos_q == ufod_pkg::LastPos);
  assign byte_take_o = byte_valid_i && (!out_valid_q || out_ready_i || !last_word);

  // One compare lane per sensor, each tied to its fixed window position.
  for (genvar g = 0; g < SENSORS; g++) begin : g_lane
    assign near_hit[g] = (pos_q == ufod_pkg::PosW'(ufod_pkg::FirstSensor + g))
                         && (byte_i < cfg_i.near_threshold);
  end

  // Only the low report bits of the near mask are shown and tested.
  for (genvar g = 0; g < ufod_pkg::ReportW; g++) begin : g_report
    if (g < SENSORS) begin : g_have
      assign mask_report[g] = mask_q[g];
    end else begin : g_none
      assign mask_report[g] = 1'b0;
    end
  end

  always_comb begin
    pos_d       = pos_q;
    skip_d      = skip_q;
    hdr1_d      = hdr1_q;
    hdr2_d      = hdr2_q;
    sum_d       = sum_q;
    mask_d      = mask_q;
    pend_d      = pend_q;
    found_d     = found_q;
    hold_d      = hold_q;
    emit        = 1'b0;
    result_d    = result_q;
    out_valid_d = out_valid_q && !out_ready_i;

    if (byte_take_o) begin
      if (skip_q != '0) begin
        skip_d = skip_q - 1'b1;
      end else begin
        if (pos_q == '0) begin
          hdr1_d = (byte_i == ufod_pkg::SyncByte);
        end
        if (pos_q == ufod_pkg::PosW'(1)) begin
          hdr2_d = (byte_i == ufod_pkg::ZeroByte);
        end
        if (pos_q >= ufod_pkg::FirstSumPos && pos_q <= ufod_pkg::LastSumPos) begin
          sum_d = sum_q + byte_i;
        end
        mask_d = mask_q | near_hit;

        // Resync search: remember the first sync word that a zero word follows.
        if (pos_q >= ufod_pkg::FirstSumPos && pend_q != '0
            && byte_i == ufod_pkg::ZeroByte && found_q == '0) begin
          found_d = pend_q;
        end
        if (pos_q != '0 && pos_q <= ufod_pkg::LastSumPos
            && byte_i == ufod_pkg::SyncByte) begin
          pend_d = pos_q;
        end else begin
          pend_d = '0;
        end

        if (pos_q != ufod_pkg::LastPos) begin
          pos_d = pos_q + 1'b1;
        end else begin
          emit                    = 1'b1;
          result_d.near_mask      = '0;
          result_d.obstacle_alert = 1'b0;
          result_d.skip_count     = '0;
          if (!(hdr1_q && hdr2_q)) begin
            result_d.frame_status = ufod_pkg::StHeaderBad;
            if (found_d != '0) begin
              result_d.skip_count = found_d;
            end else if (byte_i == ufod_pkg::SyncByte) begin
              result_d.skip_count = ufod_pkg::FullSkip;
            end
            skip_d = result_d.skip_count;
          end else if (!cfg_i.enabled) begin
            result_d.frame_status = ufod_pkg::StDisabled;
          end else if (byte_i != sum_q) begin
            result_d.frame_status = ufod_pkg::StChecksumBad;
          end else begin
            result_d.frame_status = ufod_pkg::StFrameValid;
            result_d.near_mask    = mask_report;
            if ((mask_report & cfg_i.front_mask) != '0 && hold_q == ArmCnt) begin
              result_d.obstacle_alert = 1'b1;
              hold_d                  = '0;
            end
            if (hold_d != ArmCnt) begin
              hold_d = hold_d + 1'b1;
            end
          end
          pos_d       = '0;
          hdr1_d      = 1'b0;
          hdr2_d      = 1'b0;
          sum_d       = '0;
          mask_d      = '0;
          pend_d      = '0;
          found_d     = '0;
          out_valid_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      skip_q      <= '0;
      hdr1_q      <= 1'b0;
      hdr2_q      <= 1'b0;
      sum_q       <= '0;
      mask_q      <= '0;
      pend_q      <= '0;
      found_q     <= '0;
      hold_q      <= ufod_pkg::HoldW'(1);
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      skip_q      <= skip_d;
      hdr1_q      <= hdr1_d;
      hdr2_q      <= hdr2_d;
      sum_q       <= sum_d;
      mask_q      <= mask_d;
      pend_q      <= pend_d;
      found_q     <= found_d;
      hold_q      <= hold_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

endmodule

// ===== rtl/ufod_checker.sv =====
// ----------------------------------------------------------------------------
// Port checker
// Watches the result channel of the frame detector for consistent results.
// ----------------------------------------------------------------------------
module ufod_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [1:0]                    frame_status_o,
  input logic [ufod_pkg::ReportW-1:0]  near_mask_o,
  input logic                          obstacle_alert_o,
  input logic [ufod_pkg::SkipW-1:0]    skip_count_o
);

  // A stalled result holds its word.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(frame_status_o)
      && $stable(near_mask_o) && $stable(obstacle_alert_o) && $stable(skip_count_o))
    else $error("result changed while stalled");

  // Mask and alert are only reported for a valid frame.
  a_mask_only_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_status_o != ufod_pkg::StFrameValid
      |-> near_mask_o == '0 && !obstacle_alert_o)
    else $error("mask or alert on a frame that is not valid");

  // A skip is only requested after a bad header, and never beyond a window.
  a_skip_only_bad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && skip_count_o != '0
      |-> frame_status_o == ufod_pkg::StHeaderBad && skip_count_o <= ufod_pkg::FullSkip)
    else $error("bad skip count");

  // An alert needs at least one near sensor.
  a_alert_needs_near: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && obstacle_alert_o |-> near_mask_o != '0)
    else $error("alert with empty near mask");

endmodule

bind ultrasonic_frame_obstacle_detector ufod_checker u_ufod_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .frame_status_o   (frame_status_o),
  .near_mask_o      (near_mask_o),
  .obstacle_alert_o (obstacle_alert_o),
  .skip_count_o     (skip_count_o)
);
